// ===== rtl/stcp_pkg.sv =====
// Shared types and constants for the software timer channel pool.
package stcp_pkg;

  localparam int CHANNELS = 32;
  localparam int CH_W     = 5;
  localparam int CNT_W    = 16;
  localparam int ALLOC_W  = 6;
  localparam int DIV_W    = 8;

  localparam logic [DIV_W-1:0]   TICK_DIVIDE_RESET = 8'd100;
  localparam logic [CNT_W-1:0]   COUNT_MAX         = 16'hFFFF;
  localparam logic [ALLOC_W-1:0] ALLOC_NONE        = ALLOC_W'(CHANNELS);

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_ALLOC   = 3'd1,
    OP_RELEASE = 3'd2,
    OP_START   = 3'd3,
    OP_PAUSE   = 3'd4,
    OP_SET     = 3'd5,
    OP_GET     = 3'd6,
    OP_POLL    = 3'd7
  } op_e;

  typedef struct packed {
    logic capture;
    logic execute;
  } stcp_cmd_t;

endpackage

// ===== rtl/stcp_ctrl.sv =====
// Controller state machine: capture a word, execute it, hold the result until taken.
module stcp_ctrl
  import stcp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output stcp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   exec_go;

  // execute only once the result register is free or being drained
  assign exec_go = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_go) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign cmd_o.capture = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.execute = exec_go;

endmodule

// ===== rtl/stcp_datapath.sv =====
// Datapath: channel registers, prescaler, operation execute and result register.
module stcp_datapath
  import stcp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stcp_cmd_t          cmd_i,
  input  logic               cfg_we_i,
  input  logic [DIV_W-1:0]   cfg_wdata_i,
  input  logic [2:0]         operation_i,
  input  logic [CH_W-1:0]    channel_i,
  input  logic               auto_clear_i,
  input  logic [CNT_W-1:0]   value_i,
  output logic               expired_o,
  output logic [CNT_W-1:0]   count_o,
  output logic [ALLOC_W-1:0] alloc_channel_o,
  output logic               alloc_auto_o
);

  // captured word
  op_e              op_q;
  logic [CH_W-1:0]  ch_q;
  logic             auto_q;
  logic [CNT_W-1:0] value_q;

  // channel state
  logic [CNT_W-1:0]    count_q [CHANNELS];
  logic [CHANNELS-1:0] in_use_q, running_q, pending_q;
  logic [DIV_W-1:0]    prescaler_q, tick_divide_q;

  // result register
  logic               expired_q;
  logic [CNT_W-1:0]   count_res_q;
  logic [ALLOC_W-1:0] alloc_ch_q;
  logic               alloc_auto_q;

  // lowest free channel
  logic            free_found;
  logic [CH_W-1:0] free_idx;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_found = 1'b1;
        free_idx   = CH_W'(i);
      end
    end
  end

  // poll arithmetic on the addressed channel
  logic [CNT_W-1:0] cur_cnt, inc_cnt, poll_cnt;
  logic             poll_live, poll_hit;

  always_comb begin
    cur_cnt   = count_q[ch_q];
    poll_live = pending_q[ch_q] && running_q[ch_q];
    inc_cnt   = cur_cnt;
    if (cur_cnt <= value_q && cur_cnt != COUNT_MAX) inc_cnt = cur_cnt + 1'b1;
    poll_hit  = (inc_cnt == value_q);
    poll_cnt  = inc_cnt;
    if (inc_cnt >= value_q && auto_q) poll_cnt = '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_e'(operation_i);
      ch_q    <= channel_i;
      auto_q  <= auto_clear_i;
      value_q <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_divide_q <= TICK_DIVIDE_RESET;
    end else if (cfg_we_i) begin
      tick_divide_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) count_q[i] <= '0;
      in_use_q    <= '0;
      running_q   <= '0;
      pending_q   <= '0;
      prescaler_q <= '0;
    end else if (cmd_i.execute) begin
      case (op_q)
        OP_TICK: begin
          if (prescaler_q >= tick_divide_q) begin
            prescaler_q <= '0;
            pending_q   <= '1;
          end else begin
            prescaler_q <= prescaler_q + 1'b1;
          end
        end
        OP_ALLOC: begin
          if (free_found) begin
            count_q[free_idx]   <= '0;
            in_use_q[free_idx]  <= 1'b1;
            running_q[free_idx] <= 1'b1;
          end
        end
        OP_RELEASE: begin
          count_q[ch_q]   <= '0;
          in_use_q[ch_q]  <= 1'b0;
          running_q[ch_q] <= 1'b0;
        end
        OP_START: running_q[ch_q] <= 1'b1;
        OP_PAUSE: running_q[ch_q] <= 1'b0;
        OP_SET:   count_q[ch_q] <= value_q;
        OP_POLL: begin
          in_use_q[ch_q] <= 1'b1;
          if (poll_live) begin
            pending_q[ch_q] <= 1'b0;
            count_q[ch_q]   <= poll_cnt;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      expired_q    <= (op_q == OP_POLL) && poll_live && poll_hit;
      count_res_q  <= (op_q == OP_GET) ? cur_cnt : '0;
      alloc_ch_q   <= '0;
      alloc_auto_q <= 1'b0;
      if (op_q == OP_ALLOC) begin
        alloc_ch_q   <= free_found ? ALLOC_W'(free_idx) : ALLOC_NONE;
        alloc_auto_q <= free_found && auto_q;
      end
    end
  end

  assign expired_o       = expired_q;
  assign count_o         = count_res_q;
  assign alloc_channel_o = alloc_ch_q;
  assign alloc_auto_o    = alloc_auto_q;

endmodule

// ===== rtl/soft_timer_channel_pool_top.sv =====
// Pool of 32 timer channels driven by one operation word at a time (tick, allocate,
// release, start, pause, set, get, poll), each returning exactly one result word.
// A word is captured in ST_IDLE and executed in ST_EXEC as a single read-modify-write
// of the channel registers; no new word is taken until the last one has executed.
// While a result waits behind out_stall_i the next word is still captured but is not
// executed until the result register frees. The user must write tick_divide (reset
// 100) through cfg_we_i/cfg_wdata_i only while idle; the block does not enforce it.
// Pending flags of all channels rise once every tick_divide + 1 tick words.
module soft_timer_channel_pool_top
  import stcp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [DIV_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         operation_i,
  input  logic [CH_W-1:0]    channel_i,
  input  logic               auto_clear_i,
  input  logic [CNT_W-1:0]   value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               expired_o,
  output logic [CNT_W-1:0]   count_o,
  output logic [ALLOC_W-1:0] alloc_channel_o,
  output logic               alloc_auto_o
);

  stcp_cmd_t cmd;

  stcp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  stcp_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .operation_i     (operation_i),
    .channel_i       (channel_i),
    .auto_clear_i    (auto_clear_i),
    .value_i         (value_i),
    .expired_o       (expired_o),
    .count_o         (count_o),
    .alloc_channel_o (alloc_channel_o),
    .alloc_auto_o    (alloc_auto_o)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("accepted word did not make the block busy");

  a_auto_needs_claim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && alloc_auto_o) |-> (alloc_channel_o < ALLOC_NONE))
    else $error("auto-clear mark without a claimed channel");

  a_expired_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && expired_o) |-> (count_o == '0 && alloc_channel_o == '0 && !alloc_auto_o))
    else $error("poll result carries fields of another operation");
`endif

endmodule

// ===== test/soft_timer_channel_pool_checker.sv =====
// Checker for the timer channel pool: predicts each result word and compares it.
`timescale 1ns / 100ps

module soft_timer_channel_pool_checker
  import stcp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [DIV_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         operation_i,
  input  logic [CH_W-1:0]    channel_i,
  input  logic               auto_clear_i,
  input  logic [CNT_W-1:0]   value_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               expired_i,
  input  logic [CNT_W-1:0]   count_i,
  input  logic [ALLOC_W-1:0] alloc_channel_i,
  input  logic               alloc_auto_i,
  output int                 failures_o,
  output int                 outstanding_o
);

  typedef struct packed {
    logic               expired;
    logic [CNT_W-1:0]   count;
    logic [ALLOC_W-1:0] alloc_channel;
    logic               alloc_auto;
  } pool_result_t;

  logic [CNT_W-1:0]    ch_count [CHANNELS];
  logic [CHANNELS-1:0] ch_in_use;
  logic [CHANNELS-1:0] ch_running;
  logic [CHANNELS-1:0] tick_flags;
  logic [DIV_W-1:0]    prescale;
  logic [DIV_W-1:0]    divide;
  pool_result_t        due_words [$];
  pool_result_t        seen;
  int                  fail_cnt = 0;

  assign seen = {expired_i, count_i, alloc_channel_i, alloc_auto_i};

  function automatic pool_result_t pool_apply(op_e op, logic [CH_W-1:0] ch, logic ac,
                                              logic [CNT_W-1:0] val);
    pool_result_t     r;
    logic [CNT_W-1:0] c;
    bit               claimed;
    r = '0;
    claimed = 1'b0;
    case (op)
      OP_TICK: begin
        if (prescale >= divide) begin
          prescale = '0;
          tick_flags = '1;
        end else begin
          prescale = prescale + 1'b1;
        end
      end
      OP_ALLOC: begin
        r.alloc_channel = ALLOC_NONE;
        for (int i = 0; i < CHANNELS; i++) begin
          if (!claimed && !ch_in_use[i]) begin
            claimed = 1'b1;
            ch_count[i] = '0;
            ch_in_use[i] = 1'b1;
            ch_running[i] = 1'b1;
            r.alloc_channel = ALLOC_W'(i);
            r.alloc_auto = ac;
          end
        end
      end
      OP_RELEASE: begin
        ch_count[ch] = '0;
        ch_in_use[ch] = 1'b0;
        ch_running[ch] = 1'b0;
      end
      OP_START: ch_running[ch] = 1'b1;
      OP_PAUSE: ch_running[ch] = 1'b0;
      OP_SET:   ch_count[ch] = val;
      OP_GET:   r.count = ch_count[ch];
      OP_POLL: begin
        ch_in_use[ch] = 1'b1;
        // count only on a pending tick of a running channel
        if (tick_flags[ch] && ch_running[ch]) begin
          tick_flags[ch] = 1'b0;
          c = ch_count[ch];
          if (c <= val && c != COUNT_MAX) c = c + 1'b1;
          r.expired = (c == val);
          if (c >= val && ac) c = '0;
          ch_count[ch] = c;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic match_word(pool_result_t want);
    if (seen.expired !== want.expired) begin
      $error("expired: expected %0d, got %0d", want.expired, seen.expired);
      fail_cnt++;
    end
    if (seen.count !== want.count) begin
      $error("count: expected %0h, got %0h", want.count, seen.count);
      fail_cnt++;
    end
    if (seen.alloc_channel !== want.alloc_channel) begin
      $error("alloc_channel: expected %0d, got %0d", want.alloc_channel, seen.alloc_channel);
      fail_cnt++;
    end
    if (seen.alloc_auto !== want.alloc_auto) begin
      $error("alloc_auto: expected %0d, got %0d", want.alloc_auto, seen.alloc_auto);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) ch_count[i] = '0;
      ch_in_use = '0;
      ch_running = '0;
      tick_flags = '0;
      prescale = '0;
      divide = TICK_DIVIDE_RESET;
      due_words.delete();
    end else begin
      if (cfg_we_i) divide = cfg_wdata_i;
      // drain before predicting: a word never answers itself in the same cycle
      if (out_valid_i && !out_stall_i) begin
        if (due_words.size() == 0) begin
          $error("result word with nothing expected: expired %0d count %0h alloc %0d auto %0d",
                 seen.expired, seen.count, seen.alloc_channel, seen.alloc_auto);
          fail_cnt++;
        end else begin
          match_word(due_words.pop_front());
        end
      end
      if (in_valid_i && !in_stall_i)
        due_words.push_back(pool_apply(op_e'(operation_i), channel_i, auto_clear_i, value_i));
    end
    outstanding_o <= due_words.size();
    failures_o <= fail_cnt;
  end

endmodule

// ===== test/tb.sv =====
// Testbench top for the timer channel pool: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
  import stcp_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [DIV_W-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         operation = OP_TICK;
  logic [CH_W-1:0]    channel = '0;
  logic               auto_clear = 1'b0;
  logic [CNT_W-1:0]   value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               expired;
  logic [CNT_W-1:0]   count;
  logic [ALLOC_W-1:0] alloc_channel;
  logic               alloc_auto;
  logic               quiet = 1'b0;
  int                 failures;
  int                 outstanding;

  always #6 clk = ~clk;

  soft_timer_channel_pool_top u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .operation_i     (operation),
    .channel_i       (channel),
    .auto_clear_i    (auto_clear),
    .value_i         (value),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .expired_o       (expired),
    .count_o         (count),
    .alloc_channel_o (alloc_channel),
    .alloc_auto_o    (alloc_auto)
  );

  soft_timer_channel_pool_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .operation_i     (operation),
    .channel_i       (channel),
    .auto_clear_i    (auto_clear),
    .value_i         (value),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .expired_i       (expired),
    .count_i         (count),
    .alloc_channel_i (alloc_channel),
    .alloc_auto_i    (alloc_auto),
    .failures_o      (failures),
    .outstanding_o   (outstanding)
  );

  // Offer one operation word, with an occasional gap first, and hold it until taken.
  task automatic send_op(op_e op, logic [CH_W-1:0] ch, logic ac, logic [CNT_W-1:0] val);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    channel    <= ch;
    auto_clear <= ac;
    value      <= val;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_divide(logic [DIV_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Fill the pool past full, then run a weighted mix biased to the low channels.
  task automatic run_phase(logic [DIV_W-1:0] d, int n, int tick_pct);
    op_e              op;
    logic [CH_W-1:0]  ch;
    logic [CNT_W-1:0] val;
    int               r;
    write_divide(d);
    repeat (CHANNELS + 2) send_op(OP_ALLOC, CH_W'($urandom), 1'($urandom), CNT_W'($urandom));
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < tick_pct) begin
        op = OP_TICK;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 12)      op = OP_ALLOC;
        else if (r < 20) op = OP_RELEASE;
        else if (r < 27) op = OP_START;
        else if (r < 33) op = OP_PAUSE;
        else if (r < 45) op = OP_SET;
        else if (r < 60) op = OP_GET;
        else             op = OP_POLL;
      end
      ch = ($urandom_range(0, 3) != 0) ? CH_W'($urandom_range(0, 7)) : CH_W'($urandom);
      r = $urandom_range(0, 9);
      if (op == OP_POLL || op == OP_SET) begin
        if (r < 6)      val = CNT_W'($urandom_range(0, 6));
        else if (r < 8) val = COUNT_MAX - CNT_W'($urandom_range(0, 1));
        else            val = CNT_W'($urandom);
      end else begin
        val = CNT_W'($urandom);
      end
      send_op(op, ch, 1'($urandom), val);
    end
    settle();
  endtask

  // Receiver: stall in random bursts until the quiet stretch.
  initial begin : drain
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // divide by one: every tick raises all pending flags
    write_divide(8'd0);
    send_op(OP_GET, 5'd31, 1'b0, 16'h0000);
    send_op(OP_POLL, 5'd5, 1'b1, 16'd3);      // free channel: claim without counting
    send_op(OP_ALLOC, 5'd0, 1'b1, 16'hFFFF);
    send_op(OP_ALLOC, 5'd31, 1'b0, 16'h0000);
    send_op(OP_TICK, 5'd0, 1'b0, 16'h0000);
    send_op(OP_POLL, 5'd0, 1'b1, 16'd0);      // limit zero with auto-clear
    send_op(OP_TICK, 5'd0, 1'b0, 16'h0000);
    send_op(OP_POLL, 5'd0, 1'b0, 16'd1);      // hit the limit
    send_op(OP_TICK, 5'd0, 1'b0, 16'h0000);
    send_op(OP_POLL, 5'd0, 1'b0, 16'd1);      // step past the limit
    send_op(OP_SET, 5'd0, 1'b0, COUNT_MAX);
    send_op(OP_TICK, 5'd0, 1'b0, 16'h0000);
    send_op(OP_POLL, 5'd0, 1'b1, COUNT_MAX);  // saturate at the top
    send_op(OP_GET, 5'd0, 1'b1, 16'h5A5A);
    send_op(OP_PAUSE, 5'd1, 1'b0, 16'h0000);
    send_op(OP_TICK, 5'd0, 1'b0, 16'h0000);
    send_op(OP_POLL, 5'd1, 1'b0, 16'd4);      // paused: flag stays pending
    send_op(OP_START, 5'd1, 1'b0, 16'h0000);
    send_op(OP_POLL, 5'd1, 1'b0, 16'd4);
    send_op(OP_RELEASE, 5'd0, 1'b0, 16'h0000);
    send_op(OP_ALLOC, 5'd0, 1'b1, 16'h0000);
    send_op(OP_SET, 5'd31, 1'b1, 16'hA5A5);
    send_op(OP_GET, 5'd31, 1'b0, 16'h0000);
    send_op(OP_POLL, 5'd5, 1'b0, 16'd0);      // claimed but never started
    settle();

    run_phase(8'd0, 240, 20);
    run_phase(8'd255, 320, 90);
    run_phase(DIV_W'($urandom_range(1, 6)), 260, 30);
    quiet <= 1'b1;
    run_phase(DIV_W'($urandom_range(0, 3)), 200, 25);

    if (failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
